### src/swhc_pkg.sv
// Shared types and constants for the sliding window hit counter.
// No dependencies; imported by swhc_front, swhc_back and the top level.
`default_nettype none

package swhc_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 512;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int OCC_W      = $clog2(RING_DEPTH + 1);

  // Field widths
  localparam int TS_W  = 31;
  localparam int CNT_W = 32;
  localparam int WL_W  = 10;

  localparam logic [WL_W-1:0]  WL_RESET = WL_W'(300);
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  // Front to back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic {
    OP_HIT   = 1'b0,
    OP_QUERY = 1'b1
  } swhc_op_t;

  // Classified word handed from front to back. An entry is evicted when
  // evict_en is set and its time is at or below limit.
  typedef struct packed {
    swhc_op_t        op;
    logic            evict_en;
    logic [TS_W-1:0] limit;
    logic [TS_W-1:0] ts;
  } swhc_item_t;

  // One ring entry as stored in memory
  typedef struct packed {
    logic [TS_W-1:0]  time_v;
    logic [CNT_W-1:0] count;
  } swhc_entry_t;

  localparam int ENTRY_W = $bits(swhc_entry_t);

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_EVICT = 2'd2,
    S_REPLY = 2'd3
  } swhc_state_t;

endpackage

`default_nettype wire

### src/swhc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module swhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/swhc_front.sv
// Front end: window length register, request decode and a two-word queue.
// Depends on swhc_pkg.
`default_nettype none

module swhc_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [swhc_pkg::WL_W-1:0] cfg_wdata,
  input  wire logic                     req_valid,
  output logic                          req_stall,
  input  wire logic                     req_type,
  input  wire logic [swhc_pkg::TS_W-1:0] timestamp,
  output swhc_pkg::swhc_item_t          item,
  output logic                          item_valid,
  input  wire logic                     item_pop
);
  import swhc_pkg::*;

  logic [WL_W-1:0]   window_len;
  logic [TS_W:0]     bound;
  swhc_item_t        item_in;
  swhc_item_t        qmem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_count;
  logic              push;

  // window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WL_RESET;
    end else if (cfg_we) begin
      window_len <= cfg_wdata;
    end
  end

  // classify: oldest time that survives is timestamp - window_len + 1
  assign bound            = {1'b0, timestamp} - {{(TS_W + 1 - WL_W){1'b0}}, window_len};
  assign item_in.op       = req_type ? OP_QUERY : OP_HIT;
  assign item_in.evict_en = ~bound[TS_W];
  assign item_in.limit    = bound[TS_W-1:0];
  assign item_in.ts       = timestamp;

  // queue handshake
  assign req_stall  = (q_count == QCNT_W'(QDEPTH));
  assign push       = req_valid & ~req_stall;
  assign item_valid = (q_count != '0);
  assign item       = qmem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= item_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (item_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, item_pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/swhc_back.sv
// Back end: ring control, window total, eviction sequencer and result register.
// Depends on swhc_pkg and swhc_ram.
`default_nettype none

module swhc_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire swhc_pkg::swhc_item_t      item,
  input  wire logic                      item_valid,
  output logic                           item_pop,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output logic [swhc_pkg::CNT_W-1:0]     hit_count
);
  import swhc_pkg::*;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(RING_DEPTH);

  swhc_state_t      state, state_next;
  swhc_item_t       cur;
  logic [PTR_W-1:0] head_ptr, head_ptr_next;
  logic [PTR_W-1:0] tail_ptr, tail_ptr_next;
  logic [PTR_W-1:0] newest_ptr, newest_ptr_next;
  logic [OCC_W-1:0] occupancy, occupancy_next;
  logic [CNT_W-1:0] window_total, window_total_next;
  logic [TS_W-1:0]  cache_time, cache_time_next;
  logic [CNT_W-1:0] cache_count, cache_count_next;
  logic             rsp_valid_next;
  logic [CNT_W-1:0] hit_count_next;

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  swhc_entry_t      mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  swhc_entry_t      head_entry;

  logic             occ_empty;
  logic             same_time;
  logic             evict_now;
  logic             out_free;
  logic [CNT_W-1:0] total_inc;
  logic [CNT_W-1:0] total_base;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    sat_sub = (a >= b) ? a - b : '0;
  endfunction

  // ring storage; read port always follows the head
  swhc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (head_ptr_next),
    .rdata (mem_rdata)
  );

  // oldest entry: the newest one lives in the cache and may be fresher than memory
  assign head_entry = (head_ptr == newest_ptr) ? swhc_entry_t'({cache_time, cache_count})
                                               : swhc_entry_t'(mem_rdata);

  assign occ_empty = (occupancy == '0);
  assign same_time = ~occ_empty && (cache_time == cur.ts);
  assign evict_now = ~occ_empty && cur.evict_en && (head_entry.time_v <= cur.limit);
  assign out_free  = ~rsp_valid | ~rsp_stall;
  assign total_inc = (window_total == CNT_MAX) ? window_total : window_total + 1'b1;
  assign total_base = (occupancy == OCC_FULL) ? sat_sub(total_inc, head_entry.count)
                                              : total_inc;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cur.op == OP_HIT && same_time) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_EVICT;
        end
      end
      S_EVICT: begin
        if (!evict_now) begin
          state_next = (cur.op == OP_QUERY) ? S_REPLY : S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_pop          = 1'b0;
    head_ptr_next     = head_ptr;
    tail_ptr_next     = tail_ptr;
    newest_ptr_next   = newest_ptr;
    occupancy_next    = occupancy;
    window_total_next = window_total;
    cache_time_next   = cache_time;
    cache_count_next  = cache_count;
    mem_we            = 1'b0;
    mem_waddr         = tail_ptr;
    mem_wdata         = '{time_v: cur.ts, count: CNT_W'(1)};
    rsp_valid_next    = rsp_valid & rsp_stall;
    hit_count_next    = hit_count;
    case (state)
      S_IDLE: begin
        item_pop = item_valid;
      end
      S_EXEC: begin
        if (cur.op == OP_HIT) begin
          if (same_time) begin
            // same tick as newest entry: bump it in place
            window_total_next = total_inc;
            cache_count_next  = (cache_count == CNT_MAX) ? cache_count : cache_count + 1'b1;
            mem_we            = 1'b1;
            mem_waddr         = newest_ptr;
            mem_wdata         = '{time_v: cache_time, count: cache_count_next};
          end else begin
            // append; a full ring drops its oldest entry first
            window_total_next = total_base;
            if (occupancy == OCC_FULL) begin
              head_ptr_next = ptr_inc(head_ptr);
            end else begin
              occupancy_next = occupancy + 1'b1;
            end
            mem_we           = 1'b1;
            mem_waddr        = tail_ptr;
            cache_time_next  = cur.ts;
            cache_count_next = CNT_W'(1);
            newest_ptr_next  = tail_ptr;
            tail_ptr_next    = ptr_inc(tail_ptr);
          end
        end
      end
      S_EVICT: begin
        // one expired entry popped per cycle
        if (evict_now) begin
          window_total_next = sat_sub(window_total, head_entry.count);
          head_ptr_next     = ptr_inc(head_ptr);
          occupancy_next    = occupancy - 1'b1;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          hit_count_next = window_total;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head_ptr     <= '0;
      tail_ptr     <= '0;
      newest_ptr   <= '0;
      occupancy    <= '0;
      window_total <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      head_ptr     <= head_ptr_next;
      tail_ptr     <= tail_ptr_next;
      newest_ptr   <= newest_ptr_next;
      occupancy    <= occupancy_next;
      window_total <= window_total_next;
      rsp_valid    <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_pop) begin
      cur <= item;
    end
    cache_time  <= cache_time_next;
    cache_count <= cache_count_next;
    hit_count   <= hit_count_next;
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_FULL)
    else $error("ring occupancy above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    occupancy == '0 |-> head_ptr == tail_ptr)
    else $error("empty ring with head and tail apart");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_EXEC)
    else $error("ring written outside execute");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> state == S_IDLE)
    else $error("queue popped while busy");

  a_reply_query: assert property (@(posedge clk) disable iff (rst)
    state == S_REPLY |-> cur.op == OP_QUERY)
    else $error("reply state entered for a hit");
`endif

endmodule

`default_nettype wire

### src/sliding_window_hit_counter_unit.sv
// Channel  | valid     | stall     | payload
// ---------+-----------+-----------+----------------------
// request  | req_valid | req_stall | req_type, timestamp
// response | rsp_valid | rsp_stall | hit_count
// config   | cfg_we    | -         | cfg_wdata (window_len)
//
// A hit on the newest tick passes through the back end's idle and execute states;
// a hit on a new tick also passes the evict state, and a query the evict and reply
// states; expired entries go one per cycle through the ring memory's single read port.
// A two-word queue lets the front accept while the back works.
// Synchronous reset empties the ring, clears the total, sets window_len to 300.
// The response register holds a valid response while rsp_stall is high; the back waits on it.
// Top level of the sliding window hit counter; depends on swhc_pkg,
// swhc_front, swhc_back and swhc_ram.
`default_nettype none

module sliding_window_hit_counter_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [swhc_pkg::WL_W-1:0] cfg_wdata,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire logic                      req_type,
  input  wire logic [swhc_pkg::TS_W-1:0] timestamp,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output logic [swhc_pkg::CNT_W-1:0]     hit_count
);
  import swhc_pkg::*;

  swhc_item_t item;
  logic       item_valid;
  logic       item_pop;

  // accept and classify
  swhc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .timestamp  (timestamp),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  // ring update and eviction
  swhc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .hit_count  (hit_count)
  );

endmodule

`default_nettype wire
